FILE: sv/gaoc_pkg.sv
// gaoc_pkg: shared widths, codes and reset values for the GSR average/offset calibrator.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package gaoc_pkg;

   localparam int unsigned SAMPLES_DEFAULT = 16;

   localparam int unsigned SAMPLE_W    = 12;
   localparam int unsigned OFFSET_W    = 13;
   localparam int unsigned HOLD_W      = 16;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [SAMPLE_W-1:0] ADC_MAX      = 12'd4095;
   localparam logic [SAMPLE_W-1:0] TARGET_RESET = 12'd2200;
   localparam logic [HOLD_W-1:0]   HOLD_RESET   = 16'd3000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_BASELINE = 1'b0,
      CSR_HOLD_TICKS      = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NEW_LEVEL     = 2'd0,
      EV_CAL_ENTER     = 2'd1,
      EV_CAL_STORED    = 2'd2,
      EV_CAL_REJECTED  = 2'd3
   } event_type;

   // Offset applied only with a live nonzero calibration, clamped to the ADC range.
   function automatic logic [SAMPLE_W-1:0] apply_offset(
      input logic [SAMPLE_W-1:0]        raw,
      input logic signed [OFFSET_W-1:0] offset,
      input logic                       calibrated
   );
      logic signed [OFFSET_W:0] shifted;
      logic [SAMPLE_W-1:0]      result;
      shifted = $signed({2'b00, raw}) + $signed({offset[OFFSET_W-1], offset});
      if (!calibrated || offset == '0) begin
         result = raw;
      end else if (shifted < 0) begin
         result = '0;
      end else if (shifted > $signed({2'b00, ADC_MAX})) begin
         result = ADC_MAX;
      end else begin
         result = shifted[SAMPLE_W-1:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: sv/gaoc_if.sv
// gaoc_req_if / gaoc_rsp_if: valid/ready channels for input words and result words.
// Depends on gaoc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gaoc_req_if import gaoc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [SAMPLE_W-1:0] sample;
   logic                button_level;

   modport source (output valid, kind, sample, button_level, input ready);
   modport sink   (input valid, kind, sample, button_level, output ready);
endinterface

interface gaoc_rsp_if import gaoc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [1:0]                 event_code;
   logic [SAMPLE_W-1:0]        raw_level;
   logic [SAMPLE_W-1:0]        level;
   logic signed [OFFSET_W-1:0] offset_out;
   logic                       calibrating;
   logic                       calibrated;

   modport source (output valid, event_code, raw_level, level, offset_out, calibrating,
                   calibrated, input ready);
   modport sink   (input valid, event_code, raw_level, level, offset_out, calibrating,
                   calibrated, output ready);
endinterface

`default_nettype wire

FILE: sv/gsr_average_offset_calibrator_core.sv
// gsr_average_offset_calibrator_core: sample averager with button-driven offset calibration.
// Depends on gaoc_pkg and the channel interfaces in gaoc_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word per cycle while the result register is empty or being drained: an
// ADC sample (kind 0) or a millisecond tick with the active-low button level (kind 1).
// Every SAMPLES counted samples give a new-level result; a zero sample is dropped unless
// the sample before it was a dropped zero. A release after a hold of at least hold_ticks
// ticks (with a nonzero average) enters calibrate mode; a second one stores offset =
// target_baseline - raw and leaves it, or leaves it with a reject for a full-scale raw.
// State updates and the result register load at the accepting edge. The average uses a
// constant reciprocal multiply on the accumulated sum. csr_* writes should only happen
// while no word is in flight.
module gsr_average_offset_calibrator_core import gaoc_pkg::*; #(
   parameter int unsigned SAMPLES = SAMPLES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   gaoc_req_if.sink               req_if,
   gaoc_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned SUM_W    = $clog2(SAMPLES * 4095 + 1);
   localparam int unsigned CNT_W    = $clog2(SAMPLES + 1);
   localparam int unsigned SHIFT    = SUM_W + $clog2(SAMPLES);
   localparam int unsigned RECIP_W  = SUM_W + 1;
   localparam int unsigned PROD_W   = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_FULL = ((64'd1 << SHIFT) + SAMPLES - 1) / SAMPLES;
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_FULL);
   localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(SAMPLES - 1);

   // configuration
   logic [SAMPLE_W-1:0] target_ff;
   logic [HOLD_W-1:0]   hold_ticks_ff;

   // block state
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       zero_retry_ff, zero_retry_in;
   logic [SAMPLE_W-1:0]        raw_ff, raw_in;
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic                       calibrated_ff, calibrated_in;
   logic                       calibrating_ff, calibrating_in;
   logic                       prev_pressed_ff, prev_pressed_in;
   logic [HOLD_W-1:0]          hold_ff, hold_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   event_type                  rsp_event_ff, rsp_event_in;
   logic [SAMPLE_W-1:0]        rsp_raw_ff;
   logic signed [OFFSET_W-1:0] rsp_offset_ff;
   logic                       rsp_calibrating_ff;
   logic                       rsp_calibrated_ff;

   logic               accept;
   logic               emit;
   logic               pressed;
   logic [SUM_W-1:0]   sum_next;
   logic [PROD_W-1:0]  product;
   logic [HOLD_W-1:0]  hold_inc;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign sum_next = sum_ff + SUM_W'(req_if.sample);
   assign product  = PROD_W'(sum_next) * PROD_W'(RECIP);
   assign pressed  = !req_if.button_level;
   assign hold_inc = (hold_ff != '1) ? hold_ff + 1'b1 : hold_ff;

   always_comb begin
      sum_in          = sum_ff;
      count_in        = count_ff;
      zero_retry_in   = zero_retry_ff;
      raw_in          = raw_ff;
      offset_in       = offset_ff;
      calibrated_in   = calibrated_ff;
      calibrating_in  = calibrating_ff;
      prev_pressed_in = prev_pressed_ff;
      hold_in         = hold_ff;
      emit            = 1'b0;
      rsp_event_in    = EV_NEW_LEVEL;

      if (accept) begin
         if (!req_if.kind) begin
            if (req_if.sample == '0 && !zero_retry_ff) begin
               zero_retry_in = 1'b1;
            end else begin
               zero_retry_in = 1'b0;
               if (count_ff == LAST_CNT) begin
                  // floor(sum / SAMPLES), exact over the whole sum range
                  raw_in   = product[SHIFT +: SAMPLE_W];
                  sum_in   = '0;
                  count_in = '0;
                  emit     = 1'b1;
               end else begin
                  sum_in   = sum_next;
                  count_in = count_ff + 1'b1;
               end
            end
         end else begin
            prev_pressed_in = pressed;
            if (pressed && !prev_pressed_ff) begin
               hold_in = '0;
            end else if (prev_pressed_ff) begin
               hold_in = hold_inc;
               // long hold released with a live average
               if (!pressed && hold_inc >= hold_ticks_ff && raw_ff != '0) begin
                  emit = 1'b1;
                  if (!calibrating_ff) begin
                     calibrating_in = 1'b1;
                     calibrated_in  = 1'b0;
                     rsp_event_in   = EV_CAL_ENTER;
                  end else begin
                     calibrating_in = 1'b0;
                     if (raw_ff == ADC_MAX) begin
                        rsp_event_in = EV_CAL_REJECTED;
                     end else begin
                        offset_in     = $signed({1'b0, target_ff}) - $signed({1'b0, raw_ff});
                        calibrated_in = 1'b1;
                        rsp_event_in  = EV_CAL_STORED;
                     end
                  end
               end
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff       <= TARGET_RESET;
         hold_ticks_ff   <= HOLD_RESET;
         sum_ff          <= '0;
         count_ff        <= '0;
         zero_retry_ff   <= 1'b0;
         raw_ff          <= '0;
         offset_ff       <= '0;
         calibrated_ff   <= 1'b0;
         calibrating_ff  <= 1'b0;
         prev_pressed_ff <= 1'b0;
         hold_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_TARGET_BASELINE: target_ff     <= csr_wdata[SAMPLE_W-1:0];
               CSR_HOLD_TICKS:      hold_ticks_ff <= csr_wdata[HOLD_W-1:0];
               default: ;
            endcase
         end
         sum_ff          <= sum_in;
         count_ff        <= count_in;
         zero_retry_ff   <= zero_retry_in;
         raw_ff          <= raw_in;
         offset_ff       <= offset_in;
         calibrated_ff   <= calibrated_in;
         calibrating_ff  <= calibrating_in;
         prev_pressed_ff <= prev_pressed_in;
         hold_ff         <= hold_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_event_ff       <= rsp_event_in;
         rsp_raw_ff         <= raw_in;
         rsp_offset_ff      <= offset_in;
         rsp_calibrating_ff <= calibrating_in;
         rsp_calibrated_ff  <= calibrated_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.event_code  = rsp_event_ff;
   assign rsp_if.raw_level   = rsp_raw_ff;
   assign rsp_if.offset_out  = rsp_offset_ff;
   assign rsp_if.calibrating = rsp_calibrating_ff;
   assign rsp_if.calibrated  = rsp_calibrated_ff;
   // clamp runs off the result register
   assign rsp_if.level = apply_offset(rsp_raw_ff, rsp_offset_ff, rsp_calibrated_ff);

endmodule

`default_nettype wire

FILE: sv/gaoc_checker.sv
// gaoc_checker: port-level assertions on the calibrator result channel, plus its bind.
// Depends on gaoc_pkg and gsr_average_offset_calibrator_core.
`timescale 1ns / 1ps
`default_nettype none

module gaoc_checker import gaoc_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_event_code,
   input logic [SAMPLE_W-1:0]        rsp_raw_level,
   input logic [SAMPLE_W-1:0]        rsp_level,
   input logic signed [OFFSET_W-1:0] rsp_offset_out,
   input logic                       rsp_calibrating,
   input logic                       rsp_calibrated
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code)
         && $stable(rsp_raw_level) && $stable(rsp_offset_out))
      else $error("result word changed while stalled");

   // calibrate mode always drops the previous calibration
   a_mode_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibrating |-> !rsp_calibrated)
      else $error("calibrating and calibrated both set");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == EV_CAL_ENTER |-> rsp_calibrating && rsp_raw_level != '0)
      else $error("enter event without calibrate mode");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == EV_CAL_REJECTED
         |-> !rsp_calibrating && !rsp_calibrated && rsp_raw_level == ADC_MAX)
      else $error("reject event with wrong state");

   a_uncal_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_calibrated |-> rsp_level == rsp_raw_level)
      else $error("offset applied without calibration");

endmodule

bind gsr_average_offset_calibrator_core gaoc_checker u_gaoc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_event_code  (rsp_if.event_code),
   .rsp_raw_level   (rsp_if.raw_level),
   .rsp_level       (rsp_if.level),
   .rsp_offset_out  (rsp_if.offset_out),
   .rsp_calibrating (rsp_if.calibrating),
   .rsp_calibrated  (rsp_if.calibrated)
);

`default_nettype wire

FILE: bench/gsr_tb_pkg.sv
// gsr_tb_pkg: word-kind and button-level codes shared by the calibrator bench files.
// No dependencies; compiled before the checker and the bench top.
`timescale 1ns / 1ps

package gsr_tb_pkg;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // button pin is active low
   localparam logic BTN_PRESSED  = 1'b0;
   localparam logic BTN_RELEASED = 1'b1;

endpackage

FILE: bench/gsr_level_checker.sv
// gsr_level_checker: watches the calibrator's channels and csr port, predicts each result
// word and compares it field by field. Depends on gaoc_pkg, gsr_tb_pkg and gaoc_if.sv.
`timescale 1ns / 1ps

module gsr_level_checker import gaoc_pkg::*, gsr_tb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   gaoc_req_if                    req,
   gaoc_rsp_if                    rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     reports_pending
);

   localparam int unsigned SAMPLES = SAMPLES_DEFAULT;

   typedef struct packed {
      event_type           code;
      logic [SAMPLE_W-1:0] raw;
      logic [SAMPLE_W-1:0] level;
      logic [OFFSET_W-1:0] offset;
      logic                calibrating;
      logic                calibrated;
   } level_report_type;

   level_report_type expected_reports[$];

   int unsigned                slot_sum;
   int unsigned                slot_count;
   bit                         zero_dropped;
   logic [SAMPLE_W-1:0]        raw_avg;
   logic signed [OFFSET_W-1:0] cal_offset;
   bit                         cal_valid;
   bit                         cal_mode;
   bit                         button_was_down;
   logic [HOLD_W-1:0]          press_ticks;
   logic [SAMPLE_W-1:0]        target_reg;
   logic [HOLD_W-1:0]          hold_reg;

   function automatic logic [SAMPLE_W-1:0] offset_level();
      int v;
      if (!cal_valid || cal_offset == 0) return raw_avg;
      v = int'(raw_avg) + int'(cal_offset);
      if (v < 0) v = 0;
      else if (v > int'(ADC_MAX)) v = int'(ADC_MAX);
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic post_report(event_type ev);
      level_report_type r;
      r.code        = ev;
      r.raw         = raw_avg;
      r.level       = offset_level();
      r.offset      = cal_offset;
      r.calibrating = cal_mode;
      r.calibrated  = cal_valid;
      expected_reports.push_back(r);
   endtask

   task automatic predict_word(logic kind, logic [SAMPLE_W-1:0] s, logic button);
      bit pressed;
      bit was;
      if (kind == KIND_SAMPLE) begin
         // a zero sample is thrown away unless the sample before it was a dropped zero
         if (s == 0 && !zero_dropped) begin
            zero_dropped = 1'b1;
            return;
         end
         zero_dropped = 1'b0;
         slot_sum += s;
         slot_count++;
         if (slot_count == SAMPLES) begin
            raw_avg    = SAMPLE_W'(slot_sum / SAMPLES);
            slot_sum   = 0;
            slot_count = 0;
            post_report(EV_NEW_LEVEL);
         end
         return;
      end
      pressed         = (button == BTN_PRESSED);
      was             = button_was_down;
      button_was_down = pressed;
      if (pressed && !was) begin
         press_ticks = '0;
         return;
      end
      if (!was) return;
      if (press_ticks != '1) press_ticks++;
      if (pressed) return;
      if (press_ticks < hold_reg || raw_avg == 0) return;
      if (!cal_mode) begin
         cal_mode  = 1'b1;
         cal_valid = 1'b0;
         post_report(EV_CAL_ENTER);
         return;
      end
      cal_mode = 1'b0;
      if (raw_avg >= ADC_MAX) begin
         post_report(EV_CAL_REJECTED);
         return;
      end
      cal_offset = $signed({1'b0, target_reg}) - $signed({1'b0, raw_avg});
      cal_valid  = 1'b1;
      post_report(EV_CAL_STORED);
   endtask

   task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic compare_report();
      level_report_type want;
      if (expected_reports.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected result word, expected none, got event %0d raw %0d level %0d",
                  $time, rsp.event_code, rsp.raw_level, rsp.level);
         return;
      end
      want = expected_reports.pop_front();
      check_field("event_code", want.code, rsp.event_code);
      check_field("raw_level", want.raw, rsp.raw_level);
      check_field("level", want.level, rsp.level);
      check_field("offset_out", $signed(want.offset), rsp.offset_out);
      check_field("calibrating", want.calibrating, rsp.calibrating);
      check_field("calibrated", want.calibrated, rsp.calibrated);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_reports.delete();
         mismatch_count  = 0;
         slot_sum        = 0;
         slot_count      = 0;
         zero_dropped    = 1'b0;
         raw_avg         = '0;
         cal_offset      = '0;
         cal_valid       = 1'b0;
         cal_mode        = 1'b0;
         button_was_down = 1'b0;
         press_ticks     = '0;
         target_reg      = TARGET_RESET;
         hold_reg        = HOLD_RESET;
      end else begin
         // a result word leaving now was caused by an earlier input word
         if (rsp.valid && rsp.ready) compare_report();
         if (csr_we) begin
            if (csr_index == CSR_TARGET_BASELINE) target_reg = csr_wdata[SAMPLE_W-1:0];
            else hold_reg = csr_wdata[HOLD_W-1:0];
         end
         if (req.valid && req.ready) predict_word(req.kind, req.sample, req.button_level);
      end
      reports_pending = expected_reports.size();
   end

endmodule

FILE: bench/gsr_average_offset_calibrator_core_tb.sv
// gsr_average_offset_calibrator_core_tb: drives sample/tick words and csr writes into the
// calibrator with random gaps and stalls. Depends on gaoc_pkg, gsr_tb_pkg, gaoc_if.sv,
// gsr_level_checker and the core.
`timescale 1ns / 1ps

module gsr_average_offset_calibrator_core_tb;
   import gaoc_pkg::*;
   import gsr_tb_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     mismatch_count;
   int                     reports_pending;

   bit                     quick;
   bit                     send_calm;
   bit                     sink_calm;
   int unsigned            sink_stall;
   int unsigned            words_sent;
   logic [HOLD_W-1:0]      hold_now;

   gaoc_req_if req_ch();
   gaoc_rsp_if rsp_ch();

   gsr_average_offset_calibrator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gsr_level_checker level_check (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .reports_pending (reports_pending)
   );

   always #2 clock = ~clock;

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_len(bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      rsp_ch.ready = 1'b0;
      sink_stall   = 0;
      sink_calm    = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 59) == 0) sink_calm = !sink_calm;
         if (sink_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            sink_stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) sink_stall = idle_len(sink_calm);
         end
      end
   end

   task automatic send_word(logic kind, logic [SAMPLE_W-1:0] s, logic button);
      int unsigned gap;
      if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
      gap = quick ? 0 : idle_len(send_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.sample       <= s;
      req_ch.button_level <= button;
      @(posedge clock);
      while (!(req_ch.valid && req_ch.ready)) @(posedge clock);
      words_sent++;
   endtask

   // press, h-1 more pressed ticks, release: the hold counts h ticks at release
   task automatic do_hold(int unsigned h);
      send_word(KIND_TICK, SAMPLE_W'($urandom_range(0, ADC_MAX)), BTN_PRESSED);
      repeat (h - 1) begin
         if (!quick && $urandom_range(0, 15) == 0)
            send_word(KIND_SAMPLE, SAMPLE_W'($urandom_range(1, ADC_MAX)),
                      1'($urandom_range(0, 1)));
         send_word(KIND_TICK, SAMPLE_W'($urandom_range(0, ADC_MAX)), BTN_PRESSED);
      end
      send_word(KIND_TICK, SAMPLE_W'($urandom_range(0, ADC_MAX)), BTN_RELEASED);
   endtask

   task automatic flat_slot(logic [SAMPLE_W-1:0] v);
      repeat (SAMPLES_DEFAULT) begin
         // some values get a zero ahead of them (every one when v is zero): zero dropped, value counted
         if (v == 0 || $urandom_range(0, 9) == 0)
            send_word(KIND_SAMPLE, '0, 1'($urandom_range(0, 1)));
         send_word(KIND_SAMPLE, v, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic mixed_slot();
      int unsigned r;
      repeat (SAMPLES_DEFAULT) begin
         r = $urandom_range(0, 99);
         if (r < 15) send_word(KIND_SAMPLE, '0, 1'($urandom_range(0, 1)));
         else if (r < 30) send_word(KIND_SAMPLE, ADC_MAX, 1'($urandom_range(0, 1)));
         else send_word(KIND_SAMPLE, SAMPLE_W'($urandom_range(0, ADC_MAX)),
                        1'($urandom_range(0, 1)));
      end
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_level();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 25) return ADC_MAX;
      if (r < 40) return SAMPLE_W'($urandom_range(1, 40));
      return SAMPLE_W'($urandom_range(1, ADC_MAX));
   endfunction

   function automatic int unsigned pick_hold();
      if (hold_now > 12) return $urandom_range(1, 12);
      if ($urandom_range(0, 9) < 7)
         return (hold_now > 1) ? hold_now - 1 + $urandom_range(0, 2) : 1 + $urandom_range(0, 1);
      return $urandom_range(1, hold_now + 3);
   endfunction

   task automatic random_phase(int unsigned budget);
      int unsigned first;
      first = words_sent;
      while (words_sent - first < budget) begin
         case ($urandom_range(0, 9))
            0, 1, 2: flat_slot(pick_level());
            3:       mixed_slot();
            4, 5, 6: do_hold(pick_hold());
            7:       repeat ($urandom_range(1, 5))
                        send_word(KIND_TICK, SAMPLE_W'($urandom_range(0, ADC_MAX)),
                                  BTN_RELEASED);
            default: repeat ($urandom_range(1, 6))
                        send_word(1'($urandom_range(0, 1)),
                                  SAMPLE_W'($urandom_range(0, ADC_MAX)),
                                  1'($urandom_range(0, 1)));
         endcase
      end
   endtask

   // stop sending and let every outstanding result drain
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_HOLD_TICKS) hold_now = val;
   endtask

   task automatic set_config(logic [SAMPLE_W-1:0] target, logic [HOLD_W-1:0] hold);
      write_reg(CSR_TARGET_BASELINE, CSR_DATA_W'(target));
      write_reg(CSR_HOLD_TICKS, hold);
   endtask

   initial begin
      int unsigned waited;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_TARGET_BASELINE;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.kind         = KIND_SAMPLE;
      req_ch.sample       = '0;
      req_ch.button_level = BTN_RELEASED;
      quick               = 1'b0;
      send_calm           = 1'b0;
      words_sent          = 0;
      hold_now            = HOLD_RESET;
      waited              = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: idle tick, short hold with no average yet, then one slot
      send_word(KIND_TICK, '0, BTN_RELEASED);
      send_word(KIND_TICK, ADC_MAX, BTN_PRESSED);
      send_word(KIND_TICK, '0, BTN_RELEASED);
      send_word(KIND_SAMPLE, '0, BTN_RELEASED);
      send_word(KIND_SAMPLE, '0, BTN_PRESSED);
      repeat (14) send_word(KIND_SAMPLE, ADC_MAX, BTN_RELEASED);
      send_word(KIND_SAMPLE, 12'd1, BTN_PRESSED);

      // top target, one-tick holds: enter/store, then clamp high and reject at full scale
      settle();
      set_config(ADC_MAX, 16'd1);
      do_hold(1);
      do_hold(1);
      flat_slot(ADC_MAX);
      do_hold(1);
      do_hold(1);
      random_phase(220);

      // zero target, zero hold: every release acts unless the average is zero
      settle();
      set_config('0, '0);
      flat_slot('0);
      do_hold(1);
      random_phase(220);

      settle();
      set_config(SAMPLE_W'($urandom_range(0, ADC_MAX)), HOLD_W'($urandom_range(2, 10)));
      random_phase(220);

      // back-to-back holds just under, at and over the threshold
      settle();
      set_config(TARGET_RESET, 16'd8);
      quick = 1'b1;
      mixed_slot();
      do_hold(7);
      do_hold(8);
      mixed_slot();
      do_hold(9);
      quick = 1'b0;

      settle();
      set_config(SAMPLE_W'($urandom_range(0, ADC_MAX)), HOLD_W'($urandom_range(1, 6)));
      random_phase(250);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (reports_pending != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && reports_pending == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
